[rtl/ars_pkg.sv]
// Shared types and constants for the address region set.
package ars_pkg;

	localparam int TableEntries = 16;
	localparam int AddrBits     = 48;
	localparam int FieldBits    = 48;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [1:0] CLS_NONE    = 2'd0;
	localparam logic [1:0] CLS_INSIDE  = 2'd1;
	localparam logic [1:0] CLS_PARTIAL = 2'd2;

	// scan kinds issued by the controller
	typedef enum logic [2:0] {
		SCAN_ADD   = 3'b001,
		SCAN_SPLIT = 3'b010,
		SCAN_TRIM  = 3'b100
	} scan_kind_t;

	typedef struct packed {
		logic       load;      // capture request
		logic       scan_en;   // visit current slot
		scan_kind_t kind;
		logic       first;     // restart slot index
		logic       commit;    // final write of add / split
		logic       finish;    // register result
	} ars_cmd_t;

	typedef struct packed {
		logic last;        // current slot is the last one
		logic zero_size;
		logic split_hit;   // current slot strictly contains the request
		logic [1:0] mode;
	} ars_stat_t;

endpackage

[rtl/address_region_set.sv]
// After acceptance a dispatch step finishes zero-size and unused-mode requests; add and query
// scan the table once; a remove scans for a slot strictly containing the region and splits it
// (or flags a full table), else trims the overlapping slots in a second scan.
// One request at a time; the slot scan visits one table entry per cycle.
// The next request enters in the cycle the result is taken. Asynchronous active-low reset
// empties the table and clears the result.
module address_region_set #(
	parameter int TABLE_ENTRIES = ars_pkg::TableEntries,
	parameter int ADDR_BITS     = ars_pkg::AddrBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [ars_pkg::FieldBits-1:0] region_addr,
	input  logic [ars_pkg::FieldBits-1:0] region_size,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    overlap_class,
	output logic                          table_full,
	output logic [4:0]                    regions_in_use
);

	ars_pkg::ars_cmd_t  cmd;
	ars_pkg::ars_stat_t stat;

	ars_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	ars_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.ADDR_BITS(ADDR_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .stat, .mode, .region_addr, .region_size,
		.overlap_class, .table_full, .regions_in_use
	);

endmodule

[rtl/ars_ctrl.sv]
// Controller sequencing the slot scans for one request.
module ars_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ars_pkg::ars_stat_t  stat,
	output ars_pkg::ars_cmd_t   cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ADD   = 6'b000010,
		ST_SPLIT = 6'b000100,
		ST_TRIM  = 6'b001000,
		ST_QUERY = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// a new request may enter in the cycle the pending result is taken
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.kind = ars_pkg::SCAN_ADD;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load  = 1'b1;
					cmd.first = 1'b1;
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				// dispatch after capture
				cmd.first = 1'b1;
				if (stat.zero_size) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					case (stat.mode)
						ars_pkg::MODE_ADD:    state_d = ST_ADD;
						ars_pkg::MODE_REMOVE: state_d = ST_SPLIT;
						ars_pkg::MODE_QUERY:  state_d = ST_QUERY;
						default: begin
							cmd.finish = 1'b1;
							state_d    = ST_IDLE;
						end
					endcase
				end
			end
			ST_ADD: begin
				cmd.scan_en = 1'b1;
				cmd.kind    = ars_pkg::SCAN_ADD;
				if (stat.last) begin
					cmd.commit = 1'b1;
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SPLIT: begin
				cmd.scan_en = 1'b1;
				cmd.kind    = ars_pkg::SCAN_SPLIT;
				if (stat.split_hit) begin
					cmd.commit = 1'b1;
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (stat.last) begin
					cmd.first = 1'b1;
					state_d   = ST_TRIM;
				end
			end
			ST_TRIM: begin
				cmd.scan_en = 1'b1;
				cmd.kind    = ars_pkg::SCAN_TRIM;
				if (stat.last) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_QUERY: begin
				cmd.scan_en = 1'b1;
				cmd.kind    = ars_pkg::SCAN_ADD;
				if (stat.last) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/ars_datapath.sv]
// Slot table, scan index and per-slot compare/update logic.
module ars_datapath #(
	parameter int TABLE_ENTRIES = ars_pkg::TableEntries,
	parameter int ADDR_BITS     = ars_pkg::AddrBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ars_pkg::ars_cmd_t             cmd,
	output ars_pkg::ars_stat_t            stat,
	input  logic [1:0]                    mode,
	input  logic [ars_pkg::FieldBits-1:0] region_addr,
	input  logic [ars_pkg::FieldBits-1:0] region_size,
	output logic [1:0]                    overlap_class,
	output logic                          table_full,
	output logic [4:0]                    regions_in_use
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	// bases carry the end width: a trim or split can move a base past 2^ADDR_BITS
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [ADDR_BITS:0]       base_q [TABLE_ENTRIES];
	logic [ADDR_BITS:0]       end_q  [TABLE_ENTRIES];

	logic [1:0]           mode_q;
	logic [ADDR_BITS-1:0] a_q;
	logic [ADDR_BITS:0]   e_q;
	logic                 zero_q;
	logic [IW-1:0]        idx_q;
	logic [ADDR_BITS:0]   nb_q;
	logic [ADDR_BITS:0]   ne_q;
	logic                 keep_ok_q;
	logic [IW-1:0]        keep_q;
	logic                 any_q, inside_q;
	logic [1:0]           cls_q;
	logic                 full_q;
	logic [CW-1:0]        res_count_q;

	logic [ADDR_BITS:0]   sb;
	logic [ADDR_BITS:0]   se, a_x;
	logic                 sv, ov_touch, ov_strict, contains, covered, hit_split;
	logic                 free_ok;
	logic [IW-1:0]        free_idx;

	assign sv   = valid_q[idx_q];
	assign sb   = base_q[idx_q];
	assign se   = end_q[idx_q];
	assign a_x  = {1'b0, a_q};

	assign ov_touch  = sv && (sb <= e_q) && (se >= a_x);
	assign ov_strict = sv && (sb < e_q) && (se > a_x);
	assign contains  = (sb < a_x) && (se > e_q);
	assign covered   = (sb >= a_x) && (se <= e_q);
	assign hit_split = sv && contains;

	// lowest free slot
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok  = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign stat.last      = (idx_q == IW'(TABLE_ENTRIES - 1));
	assign stat.zero_size = zero_q;
	assign stat.split_hit = hit_split;
	assign stat.mode      = mode_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			a_q    <= region_addr[ADDR_BITS-1:0];
			e_q    <= {1'b0, region_addr[ADDR_BITS-1:0]} + {1'b0, region_size[ADDR_BITS-1:0]};
			zero_q <= (region_size[ADDR_BITS-1:0] == '0);
			nb_q   <= {1'b0, region_addr[ADDR_BITS-1:0]};
			ne_q   <= {1'b0, region_addr[ADDR_BITS-1:0]} + {1'b0, region_size[ADDR_BITS-1:0]};
		end
		if (cmd.scan_en && cmd.kind == ars_pkg::SCAN_ADD && ov_touch) begin
			if (sb < nb_q) nb_q <= sb;
			if (se > ne_q) ne_q <= se;
			if (!keep_ok_q) keep_q <= idx_q;
		end
		if (cmd.scan_en && cmd.kind == ars_pkg::SCAN_TRIM && ov_strict && !covered) begin
			if (sb >= a_x) base_q[idx_q] <= e_q;
			else end_q[idx_q] <= a_x;
		end
		if (cmd.commit && cmd.kind == ars_pkg::SCAN_ADD) begin
			if (keep_ok_q || ov_touch) begin
				base_q[(keep_ok_q ? keep_q : idx_q)] <= (ov_touch && sb < nb_q) ? sb : nb_q;
				end_q[(keep_ok_q ? keep_q : idx_q)]  <= (ov_touch && se > ne_q) ? se : ne_q;
			end else if (free_ok) begin
				base_q[free_idx] <= nb_q;
				end_q[free_idx]  <= ne_q;
			end
		end
		if (cmd.commit && cmd.kind == ars_pkg::SCAN_SPLIT && free_ok) begin
			base_q[free_idx] <= e_q;
			end_q[free_idx]  <= se;
			end_q[idx_q]     <= a_x;
		end
	end

	logic [TABLE_ENTRIES-1:0] valid_d;
	logic                     full_d;
	logic [1:0]               cls_d;
	logic                     any_d, inside_d;

	always_comb begin
		valid_d  = valid_q;
		full_d   = 1'b0;
		any_d    = any_q;
		inside_d = inside_q;
		if (cmd.scan_en && cmd.kind == ars_pkg::SCAN_ADD && ov_touch && keep_ok_q
				&& mode_q == ars_pkg::MODE_ADD)
			valid_d[idx_q] = 1'b0;
		if (cmd.scan_en && cmd.kind == ars_pkg::SCAN_TRIM && ov_strict && covered)
			valid_d[idx_q] = 1'b0;
		if (cmd.scan_en && cmd.kind == ars_pkg::SCAN_ADD && mode_q == ars_pkg::MODE_QUERY
				&& ov_strict) begin
			any_d = 1'b1;
			if (a_x >= sb && e_q <= se) inside_d = 1'b1;
		end
		if (cmd.commit && cmd.kind == ars_pkg::SCAN_ADD) begin
			if (keep_ok_q)
				valid_d[keep_q] = 1'b1;
			else if (ov_touch)
				valid_d[idx_q] = 1'b1;
			else if (free_ok)
				valid_d[free_idx] = 1'b1;
			else
				full_d = 1'b1;
		end
		if (cmd.commit && cmd.kind == ars_pkg::SCAN_SPLIT) begin
			if (free_ok) valid_d[free_idx] = 1'b1;
			else full_d = 1'b1;
		end
		if (inside_d) cls_d = ars_pkg::CLS_INSIDE;
		else if (any_d) cls_d = ars_pkg::CLS_PARTIAL;
		else cls_d = ars_pkg::CLS_NONE;
		if (mode_q != ars_pkg::MODE_QUERY || zero_q) cls_d = ars_pkg::CLS_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			idx_q       <= '0;
			keep_ok_q   <= 1'b0;
			any_q       <= 1'b0;
			inside_q    <= 1'b0;
			cls_q       <= ars_pkg::CLS_NONE;
			full_q      <= 1'b0;
			res_count_q <= '0;
		end else begin
			valid_q <= valid_d;
			if (cmd.first) begin
				idx_q     <= '0;
				keep_ok_q <= 1'b0;
				any_q     <= 1'b0;
				inside_q  <= 1'b0;
			end else if (cmd.scan_en) begin
				idx_q    <= idx_q + IW'(1);
				any_q    <= any_d;
				inside_q <= inside_d;
				if (cmd.kind == ars_pkg::SCAN_ADD && ov_touch)
					keep_ok_q <= 1'b1;
			end
			if (cmd.finish) begin
				cls_q       <= cls_d;
				full_q      <= full_d;
				res_count_q <= CW'($countones(valid_d));
			end
		end
	end

	assign overlap_class  = cls_q;
	assign table_full     = full_q;
	assign regions_in_use = 5'(res_count_q);

endmodule

[rtl/ars_checker.sv]
// Port-level checks for the address region set, bound to the top level.
module ars_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] overlap_class,
	input logic       table_full,
	input logic [4:0] regions_in_use
);

	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request accepted with result pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(regions_in_use))
		else $error("result dropped before taken");

	a_cls_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> overlap_class <= ars_pkg::CLS_PARTIAL && regions_in_use <= 5'd16)
		else $error("result out of range");

	a_full_no_cls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> overlap_class == ars_pkg::CLS_NONE)
		else $error("full flag on query");

endmodule

bind address_region_set ars_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.overlap_class, .table_full, .regions_in_use
);
